/* sv/warr_pkg.sv */
package warr_pkg;

	localparam int WINDOW_DEPTH = 16;

	localparam int MV_W    = 12;
	localparam int CFG_CNT_W = 5;
	localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W   = $clog2(WINDOW_DEPTH * 4095 + 1);
	localparam int STEP_W  = $clog2(SUM_W);
	localparam int CMP_W   = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_LOWER_LIMIT  = 2'd0,
		REG_UPPER_LIMIT  = 2'd1,
		REG_ALLOWED_INV  = 2'd2
	} reg_idx_t;

	localparam logic [MV_W-1:0]      LOWER_LIMIT_RST = '0;
	localparam logic [MV_W-1:0]      UPPER_LIMIT_RST = MV_W'(4095);
	localparam logic [CFG_CNT_W-1:0] ALLOWED_INV_RST = '0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            bad;
		logic [MV_W-1:0] mv;
	} win_entry_t;

	typedef struct packed {
		logic [MV_W-1:0] sample_mv;
	} sample_t;

	typedef struct packed {
		logic [MV_W-1:0]      average_mv;
		logic [CFG_CNT_W-1:0] used_count;
		logic [CFG_CNT_W-1:0] invalid_count;
		logic                 too_many_invalid;
		logic                 no_valid_samples;
	} result_t;

endpackage

/* sv/warr_sample_if.sv */
interface warr_sample_if;
	import warr_pkg::*;

	logic    valid;
	logic    ready;
	sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* sv/warr_result_if.sv */
interface warr_result_if;
	import warr_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* sv/windowed_average_range_reject.sv */
// Windowed average with range rejection.
// samples (valid/ready) takes one 12-bit millivolt sample per request. It is
// written into a 16-slot circular window with an out-of-range flag taken
// from the lower and upper limit registers at the moment of acceptance.
// results (valid/ready) returns one result per sample: mean of the valid
// nonzero window entries, the counts of used and invalid entries, and the
// two error flags.
// Running totals are updated by one read-modify-write of the window memory
// (registered read); the mean comes from a restoring divider that retires
// one quotient bit per cycle over the 16-bit sum.
// Sequence: accept, an update state, the divider steps, then a load state;
// a new sample is taken only once the result is loaded (the divider is
// skipped when no entry qualifies).
// The result register frees the core: a stalled receiver holds the result,
// and the core finishes the next sample and waits in its load cycle.
// Reset clears the limits to 0 and 4095, allowed_invalid to 0, the totals
// and the per-slot written flags; an unwritten slot reads as zero. Write
// the APB registers only while no sample is in flight.
module windowed_average_range_reject (
	input  logic                          clk,
	input  logic                          arst_n,
	warr_sample_if.sink                   samples,
	warr_result_if.source                 results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [warr_pkg::PADDR_W-1:0]  paddr,
	input  logic [warr_pkg::PDATA_W-1:0]  pwdata,
	output logic [warr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import warr_pkg::*;

	// configuration
	logic [MV_W-1:0]      lower_q;
	logic [MV_W-1:0]      upper_q;
	logic [CFG_CNT_W-1:0] allowed_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	// window memory and written flags
	win_entry_t                mem [WINDOW_DEPTH];
	win_entry_t                rd_q;
	logic [WINDOW_DEPTH-1:0]   written_q;
	logic [SLOT_W-1:0]         slot_q;

	// running totals
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] bad_q;

	win_entry_t       new_q;
	win_entry_t       old_entry;
	logic             old_used;
	logic             new_used;
	logic [SUM_W-1:0] sum_nxt;
	logic [CNT_W-1:0] used_nxt;
	logic [CNT_W-1:0] bad_nxt;

	// divider
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_diff;
	logic              rem_ge;

	// control
	state_t  state_q;
	state_t  state_nxt;
	logic    accept;
	logic    res_load;
	result_t res_q;
	logic    res_valid_q;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_LOWER_LIMIT: prdata = PDATA_W'(lower_q);
			REG_UPPER_LIMIT: prdata = PDATA_W'(upper_q);
			REG_ALLOWED_INV: prdata = PDATA_W'(allowed_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q   <= LOWER_LIMIT_RST;
			upper_q   <= UPPER_LIMIT_RST;
			allowed_q <= ALLOWED_INV_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LOWER_LIMIT: lower_q   <= pwdata[MV_W-1:0];
				REG_UPPER_LIMIT: upper_q   <= pwdata[MV_W-1:0];
				REG_ALLOWED_INV: allowed_q <= pwdata[CFG_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------- sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (samples.valid) state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = (used_nxt != '0) ? ST_DIV : ST_DONE;
			ST_DIV:    if (step_q == '0) state_nxt = ST_DONE;
			ST_DONE:   if (!res_valid_q || results.ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = 1'b0;
		res_load      = 1'b0;
		case (state_q)
			ST_IDLE: samples.ready = 1'b1;
			ST_DONE: res_load = !res_valid_q || results.ready;
			default: ;
		endcase
	end

	assign accept = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------- window read/write
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[slot_q];
		end
		if (state_q == ST_UPDATE) begin
			mem[slot_q] <= new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.mv  <= samples.data.sample_mv;
			new_q.bad <= (samples.data.sample_mv < lower_q) ||
				(samples.data.sample_mv > upper_q);
		end
	end

	// an unwritten slot reads as a zero sample that is not flagged
	assign old_entry = written_q[slot_q] ? rd_q : '0;
	assign old_used  = !old_entry.bad && (old_entry.mv != '0);
	assign new_used  = !new_q.bad && (new_q.mv != '0);

	always_comb begin
		sum_nxt  = sum_q - (old_used ? SUM_W'(old_entry.mv) : '0)
			+ (new_used ? SUM_W'(new_q.mv) : '0);
		used_nxt = used_q - CNT_W'(old_used) + CNT_W'(new_used);
		bad_nxt  = bad_q - CNT_W'(old_entry.bad) + CNT_W'(new_q.bad);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			slot_q    <= '0;
			sum_q     <= '0;
			used_q    <= '0;
			bad_q     <= '0;
		end else if (state_q == ST_UPDATE) begin
			written_q[slot_q] <= 1'b1;
			slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			sum_q  <= sum_nxt;
			used_q <= used_nxt;
			bad_q  <= bad_nxt;
		end
	end

	// ------------------------------------------------------------ divider
	assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, div_q};
	assign rem_diff = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			// with nothing to average the quotient stays zero
			quo_q  <= (used_nxt != '0) ? sum_nxt : '0;
			rem_q  <= '0;
			div_q  <= used_nxt;
			step_q <= STEP_W'(SUM_W - 1);
		end else if (state_q == ST_DIV) begin
			quo_q  <= {quo_q[SUM_W-2:0], rem_ge};
			rem_q  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			step_q <= step_q - 1'b1;
		end
	end

	// ------------------------------------------------------ result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.average_mv       <= quo_q[MV_W-1:0];
			res_q.used_count       <= CFG_CNT_W'(used_q);
			res_q.invalid_count    <= CFG_CNT_W'(bad_q);
			res_q.too_many_invalid <= CMP_W'(bad_q) > CMP_W'(allowed_q);
			res_q.no_valid_samples <= (used_q == '0);
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	// --------------------------------------------------------- assertions
	a_totals_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(used_q) + (CNT_W + 1)'(bad_q) <= (CNT_W + 1)'(WINDOW_DEPTH))
		else $error("window totals exceed window depth");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == '0) |-> (sum_q == '0))
		else $error("nonzero sum with no entry in use");

	a_slot_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (slot_q != $past(slot_q)))
		else $error("write slot did not advance after update");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the load cycle");

endmodule
